// ===== rtl/tcc_pkg.sv =====
// shared types and constants of the text console cursor engine
// no dependencies

package tcc_pkg;

  localparam int SCREEN_ROWS_DEF      = 25;
  localparam int SCREEN_COLS_DEF      = 80;
  localparam int STATUS_START_ROW_DEF = 23;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam logic [7:0]  RESET_BLANK_ATTR = 8'h07;
  localparam logic [15:0] RESET_BLANK_CELL = {RESET_BLANK_ATTR, CH_SPACE};

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SET   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [4:0]  row;
    logic [6:0]  col;
  } in_req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  row_pos;
    logic [6:0]  col_pos;
    logic [10:0] cursor_position;
  } out_res_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_EXEC,
    DP_COPY,
    DP_BLANK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   init_fill;
  } tcc_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    scroll;
    logic    copy_last;
    logic    blank_last;
    logic    fill_last;
  } tcc_stat_t;

endpackage

// ===== rtl/tcc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcc_ctrl.sv =====
// control state machine of the text console cursor engine
// depends on tcc_pkg

module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  tcc_stat_t stat,
  output tcc_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_CLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;
  logic   emit;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = DP_HOLD;
    cmd.init_fill = 1'b0;
    emit          = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.op        = DP_BLANK;
        cmd.init_fill = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.op = DP_EXEC;
        if (stat.opcode == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if (stat.opcode == OP_PUT && stat.scroll) begin
          state_nxt = ST_COPY;
        end else begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
        end
      end
      ST_COPY: begin
        cmd.op = DP_COPY;
        if (stat.copy_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.op = DP_BLANK;
        if (stat.blank_last) begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.op = DP_BLANK;
        if (stat.fill_last) begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != ST_IDLE);
      out_valid_r <= emit;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/tcc_dpath.sv =====
// datapath: screen ram, cursor, scroll and fill counter, result registers
// depends on tcc_pkg and tcc_ram

module tcc_dpath
  import tcc_pkg::*;
#(
  parameter int SCREEN_ROWS      = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS      = SCREEN_COLS_DEF,
  parameter int STATUS_START_ROW = STATUS_START_ROW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_req_t    in_req,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  tcc_cmd_t   cmd,
  output tcc_stat_t  stat,
  output out_res_t   out_res
);

  localparam int CELLS     = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW        = $clog2(CELLS);
  localparam int ROW_W     = $clog2(SCREEN_ROWS);
  localparam int COL_W     = $clog2(SCREEN_COLS);
  localparam int ROW_X     = ROW_W + 1;
  localparam int COL_X     = $clog2(SCREEN_COLS + 4);
  localparam int TOP_ROW   = (STATUS_START_ROW < SCREEN_ROWS) ? STATUS_START_ROW : SCREEN_ROWS;
  localparam int LAST_ROW  = TOP_ROW - 1;
  localparam int COPY_END  = LAST_ROW * SCREEN_COLS - 1;
  localparam int BLANK_END = (LAST_ROW + 1) * SCREEN_COLS - 1;
  localparam int FILL_END  = CELLS - 1;

  in_req_t          req_r;
  logic [7:0]       blank_attr_r;
  logic [ROW_W-1:0] cur_row_r;
  logic [COL_W-1:0] cur_col_r;
  logic [15:0]      cell_r;
  logic [AW-1:0]    cnt_r;
  logic             pend_r;
  logic [AW-1:0]    wa_r;

  logic [ROW_X-1:0] row_a;
  logic [COL_X-1:0] col_a;
  logic             printable;
  logic             scroll;
  logic [ROW_W-1:0] set_row;
  logic [COL_W-1:0] set_col;
  logic             rd_ok;
  logic             in_ok;
  logic [AW-1:0]    in_addr;
  logic [AW-1:0]    cur_addr;

  logic             ram_we;
  logic [AW-1:0]    ram_wa;
  logic [15:0]      ram_wd;
  logic [AW-1:0]    ram_ra;
  logic [15:0]      ram_rd;

  // cursor advance for put character
  always_comb begin
    row_a     = ROW_X'(cur_row_r);
    col_a     = COL_X'(cur_col_r);
    printable = 1'b0;
    case (req_r.char_code)
      CH_NEWLINE: begin
        col_a = '0;
        row_a = row_a + ROW_X'(1);
      end
      CH_RETURN: begin
        col_a = '0;
      end
      CH_TAB: begin
        col_a = (col_a + COL_X'(4)) & ~COL_X'(3);
      end
      default: begin
        col_a     = col_a + COL_X'(1);
        printable = 1'b1;
      end
    endcase
    if (32'(col_a) >= SCREEN_COLS) begin
      col_a = '0;
      row_a = row_a + ROW_X'(1);
    end
  end

  assign scroll  = (32'(row_a) >= LAST_ROW);
  assign set_row = (32'(req_r.row) < SCREEN_ROWS) ? ROW_W'(req_r.row) : ROW_W'(SCREEN_ROWS - 1);
  assign set_col = (32'(req_r.col) < SCREEN_COLS) ? COL_W'(req_r.col) : COL_W'(SCREEN_COLS - 1);
  assign rd_ok   = (32'(req_r.row) < SCREEN_ROWS) && (32'(req_r.col) < SCREEN_COLS);
  assign in_ok   = (32'(in_req.row) < SCREEN_ROWS) && (32'(in_req.col) < SCREEN_COLS);
  assign in_addr = in_ok ? AW'(32'(in_req.row) * SCREEN_COLS + 32'(in_req.col)) : '0;
  assign cur_addr = AW'(32'(cur_row_r) * SCREEN_COLS + 32'(cur_col_r));

  // ram port selection
  always_comb begin
    ram_we = 1'b0;
    ram_wa = cnt_r;
    ram_wd = cmd.init_fill ? RESET_BLANK_CELL : {blank_attr_r, CH_SPACE};
    ram_ra = in_addr;
    if (cmd.op == DP_COPY) begin
      ram_ra = cnt_r + AW'(SCREEN_COLS);
    end
    if (pend_r) begin
      ram_we = 1'b1;
      ram_wa = wa_r;
      ram_wd = ram_rd;
    end
    case (cmd.op)
      DP_EXEC: begin
        if (req_r.opcode == OP_PUT && printable) begin
          ram_we = 1'b1;
          ram_wa = cur_addr;
          ram_wd = {req_r.attribute, req_r.char_code};
        end
      end
      DP_BLANK: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcc_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_wa),
    .wdata(ram_wd),
    .raddr(ram_ra),
    .rdata(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_attr_r <= RESET_BLANK_ATTR;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        blank_attr_r <= cfg_data;
      end
      pend_r <= (cmd.op == DP_COPY);
      case (cmd.op)
        DP_EXEC: begin
          cnt_r <= '0;
          case (req_r.opcode)
            OP_PUT: begin
              if (scroll) begin
                cur_row_r <= ROW_W'(LAST_ROW - 1);
                cur_col_r <= '0;
              end else begin
                cur_row_r <= ROW_W'(row_a);
                cur_col_r <= COL_W'(col_a);
              end
            end
            OP_CLEAR: begin
              cur_row_r <= '0;
              cur_col_r <= '0;
            end
            OP_SET: begin
              cur_row_r <= set_row;
              cur_col_r <= set_col;
            end
            default: begin
            end
          endcase
        end
        DP_COPY, DP_BLANK: begin
          cnt_r <= cnt_r + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wa_r <= cnt_r;
    if (cmd.op == DP_LOAD) begin
      req_r <= in_req;
    end
    if (cmd.op == DP_EXEC) begin
      cell_r <= (req_r.opcode == OP_READ && rd_ok) ? ram_rd : 16'h0000;
    end
  end

  assign stat.opcode     = req_r.opcode;
  assign stat.scroll     = scroll;
  assign stat.copy_last  = (cnt_r == AW'(COPY_END));
  assign stat.blank_last = (cnt_r == AW'(BLANK_END));
  assign stat.fill_last  = (cnt_r == AW'(FILL_END));

  assign out_res.cell_value      = cell_r;
  assign out_res.row_pos         = 5'(cur_row_r);
  assign out_res.col_pos         = 7'(cur_col_r);
  assign out_res.cursor_position = 11'(32'(cur_row_r) * SCREEN_COLS + 32'(cur_col_r));

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// Text console with cursor and scroll. A request is taken when start is high and busy is
// low; its result appears on out_res for one cycle with out_valid and cannot be held off.
// Put character without scroll, set cursor and read cell raise the strobe in the same cycle
// that busy falls, so a new request can be taken while the result is shown. A put character
// that scrolls copies the scroll region one cell per cycle through the single write port
// of the screen ram, moving rows 1 to L up by one row and then blanking row L, L being
// min(STATUS_START_ROW, SCREEN_ROWS) - 1. Clear screen writes every cell. After reset the
// block blanks every cell of the screen with busy high; blank_attribute writes are taken at
// any time on cfg_we.
// depends on tcc_pkg, tcc_ctrl, tcc_dpath

module text_console_cursor_engine
  import tcc_pkg::*;
#(
  parameter int SCREEN_ROWS      = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS      = SCREEN_COLS_DEF,
  parameter int STATUS_START_ROW = STATUS_START_ROW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_req_t    in_req,
  output logic       out_valid,
  output out_res_t   out_res,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  tcc_cmd_t  cmd;
  tcc_stat_t stat;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  tcc_dpath #(
    .SCREEN_ROWS     (SCREEN_ROWS),
    .SCREEN_COLS     (SCREEN_COLS),
    .STATUS_START_ROW(STATUS_START_ROW)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

endmodule

// ===== rtl/tcc_checker.sv =====
// port-level checks of the text console cursor engine, bound to the top level
// depends on tcc_pkg and text_console_cursor_engine

module tcc_checker
  import tcc_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    start,
  input logic    busy,
  input in_req_t in_req,
  input logic    out_valid
);

  logic accept;
  assign accept = start && !busy;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low after a request was taken");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req.opcode == OP_SET || in_req.opcode == OP_READ) |-> ##2 out_valid)
    else $error("set cursor or read cell result missing");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (.*);
